@@ hdl/assert_macros.svh @@
// Assertion macros shared by the sweep event queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SEPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sepq: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define SEPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sepq: next-cycle check failed");

`endif

@@ hdl/sepq_pkg.sv @@
// Types, codes and helpers for the sweep event priority queue.
package sepq_pkg;

  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 10;

  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_DELETE  = 2'd1,
    KIND_EXTRACT = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_ABSENT = 3'd3,
    ST_DUP    = 3'd4
  } status_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] x;
    logic signed [KEY_W-1:0] z;
    logic [HANDLE_W-1:0]     owner;
  } slot_t;

  typedef struct packed {
    logic owner_match;
    logic goes_before;
  } cmp_res_t;

  function automatic logic signed [KEY_W-1:0] sat_add(input logic signed [KEY_W-1:0] a,
                                                      input logic signed [KEY_W-1:0] b);
    logic signed [KEY_W:0] sum;
    sum = (KEY_W+1)'(a) + (KEY_W+1)'(b);
    if (sum[KEY_W] != sum[KEY_W-1]) begin
      sat_add = sum[KEY_W] ? {1'b1, {(KEY_W-1){1'b0}}} : {1'b0, {(KEY_W-1){1'b1}}};
    end else begin
      sat_add = sum[KEY_W-1:0];
    end
  endfunction

endpackage

@@ hdl/sepq_ram.sv @@
// Slot store: one write port, one read port with registered data.
module sepq_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 106
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/sepq_cmp.sv @@
// Shared compare unit: order test and owner match of a new entry against one slot.
module sepq_cmp (
  input  sepq_pkg::slot_t                    slot,
  input  logic signed [sepq_pkg::KEY_W-1:0]  new_key,
  input  logic signed [sepq_pkg::KEY_W-1:0]  new_x,
  input  logic [sepq_pkg::HANDLE_W-1:0]      new_owner,
  output sepq_pkg::cmp_res_t                 res
);
  import sepq_pkg::*;

  logic signed [KEY_W-1:0] slot_key;
  logic signed [KEY_W-1:0] slot_x;

  assign slot_key = $signed(slot.key);
  assign slot_x   = $signed(slot.x);

  assign res.owner_match = (slot.owner == new_owner);
  assign res.goes_before = (new_key < slot_key) || ((new_key == slot_key) && (new_x <= slot_x));

endmodule

@@ hdl/sweep_event_priority_queue.sv @@
// Sweep event priority queue: sorted slot store walked by a sequencer around one compare unit.
// An unused kind goes straight to the head read and report; other kinds scan the held entries,
// then shift to add or remove one; handle reduction runs first when HANDLE_COUNT is below 1024.
// The scan and the shift each take one slot a cycle through the single slot-store read port.
// One item at a time; busy stays high until the result beat. Results cannot be stalled.
// Reset clears the count and the sequencer; slot contents need no clearing pass.
`include "assert_macros.svh"

module sweep_event_priority_queue #(
  parameter int CAPACITY     = 256,
  parameter int HANDLE_COUNT = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          kind,
  input  logic [sepq_pkg::HANDLE_W-1:0]       handle,
  input  logic signed [sepq_pkg::KEY_W-1:0]   site_y,
  input  logic signed [sepq_pkg::KEY_W-1:0]   site_x,
  input  logic signed [sepq_pkg::KEY_W-1:0]   site_z,
  input  logic signed [sepq_pkg::KEY_W-1:0]   offset,
  output logic                                done,
  output logic                                taken_valid,
  output logic [sepq_pkg::HANDLE_W-1:0]       taken_handle,
  output logic                                head_valid,
  output logic signed [sepq_pkg::KEY_W-1:0]   head_key,
  output logic signed [sepq_pkg::KEY_W-1:0]   head_x,
  output logic signed [sepq_pkg::KEY_W-1:0]   head_z,
  output logic [$clog2(CAPACITY+1)-1:0]       entry_total,
  output logic [2:0]                          status
);
  import sepq_pkg::*;

  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int RED_W    = $clog2(HANDLE_COUNT + 1) + HANDLE_W;
  localparam bit NEED_RED = HANDLE_COUNT < (1 << HANDLE_W);
  localparam int STEP_W   = $clog2(HANDLE_W);
  localparam int SLOT_W   = $bits(slot_t);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_REDUCE   = 7'b0000010,
    S_SCAN     = 7'b0000100,
    S_SHIFT_UP = 7'b0001000,
    S_SHIFT_DN = 7'b0010000,
    S_HEAD     = 7'b0100000,
    S_REPORT   = 7'b1000000
  } state_t;

  state_t                  state;
  kind_t                   op;
  logic [HANDLE_W-1:0]     hnd;
  logic signed [KEY_W-1:0] nkey;
  logic signed [KEY_W-1:0] nx;
  logic signed [KEY_W-1:0] nz;
  logic [CW-1:0]           count;
  logic [CW-1:0]           iss;
  logic [CW-1:0]           chk_idx;
  logic [CW-1:0]           pos;
  logic [CW-1:0]           p;
  logic [CW-1:0]           wa;
  logic                    chk_valid;
  logic                    pos_set;
  logic                    dup;
  logic                    wv;
  logic [STEP_W-1:0]       red_step;
  status_t                 st;
  logic                    tv;
  logic [HANDLE_W-1:0]     th;

  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;
  logic                    wr_en;
  slot_t                   wr_data;
  slot_t                   rd_data;
  slot_t                   fresh;
  cmp_res_t                cmp;
  logic [CW-1:0]           p_dec;
  logic [CW-1:0]           p_inc;
  logic [RED_W-1:0]        rem_wide;
  logic [RED_W-1:0]        sub;
  logic [RED_W-1:0]        diff;
  logic                    scan_hit;
  logic                    scan_drained;

  assign busy     = (state != S_IDLE);
  assign fresh    = '{key: nkey, x: nx, z: nz, owner: hnd};
  assign p_dec    = p - CW'(1);
  assign p_inc    = p + CW'(1);
  assign rem_wide = RED_W'(hnd);
  assign sub      = RED_W'(HANDLE_COUNT) << red_step;
  assign diff     = rem_wide - sub;

  assign scan_hit     = chk_valid && (op != KIND_INSERT) &&
                        ((op == KIND_EXTRACT) || cmp.owner_match);
  assign scan_drained = !chk_valid && (iss == count);

  always_comb begin
    unique case (state)
      S_SCAN:     rd_addr = iss[AW-1:0];
      S_SHIFT_UP: rd_addr = p_dec[AW-1:0];
      S_SHIFT_DN: rd_addr = p_inc[AW-1:0];
      default:    rd_addr = '0;
    endcase
  end

  assign wr_en   = ((state == S_SHIFT_UP) && (wv || (p == pos))) ||
                   ((state == S_SHIFT_DN) && wv);
  assign wr_addr = wv ? wa[AW-1:0] : pos[AW-1:0];
  assign wr_data = wv ? rd_data : fresh;

  sepq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (SLOT_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sepq_cmp u_cmp (
    .slot      (rd_data),
    .new_key   (nkey),
    .new_x     (nx),
    .new_owner (hnd),
    .res       (cmp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      done      <= 1'b0;
      wv        <= 1'b0;
      chk_valid <= 1'b0;
    end else begin
      done <= (state == S_REPORT);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op        <= kind_t'(kind);
            hnd       <= handle;
            nkey      <= sat_add(site_y, offset);
            nx        <= site_x;
            nz        <= site_z;
            st        <= ST_OK;
            tv        <= 1'b0;
            th        <= '0;
            iss       <= '0;
            chk_valid <= 1'b0;
            pos_set   <= 1'b0;
            dup       <= 1'b0;
            red_step  <= STEP_W'(HANDLE_W - 1);
            if (NEED_RED) begin
              state <= S_REDUCE;
            end else if (kind_t'(kind) == KIND_NONE) begin
              state <= S_HEAD;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_REDUCE: begin
          if (rem_wide >= sub) begin
            hnd <= diff[HANDLE_W-1:0];
          end
          red_step <= red_step - STEP_W'(1);
          if (red_step == '0) begin
            state <= (op == KIND_NONE) ? S_HEAD : S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            pos       <= chk_idx;
            p         <= chk_idx;
            wv        <= 1'b0;
            chk_valid <= 1'b0;
            if (op == KIND_EXTRACT) begin
              tv <= 1'b1;
              th <= rd_data.owner;
            end
            state <= S_SHIFT_DN;
          end else if (scan_drained) begin
            if (op == KIND_INSERT) begin
              if (dup) begin
                st    <= ST_DUP;
                state <= S_HEAD;
              end else if (count == CW'(CAPACITY)) begin
                st    <= ST_FULL;
                state <= S_HEAD;
              end else begin
                p     <= count;
                pos   <= pos_set ? pos : count;
                wv    <= 1'b0;
                state <= S_SHIFT_UP;
              end
            end else begin
              st    <= (op == KIND_EXTRACT) ? ST_EMPTY : ST_ABSENT;
              state <= S_HEAD;
            end
          end else begin
            if (chk_valid && (op == KIND_INSERT)) begin
              if (cmp.owner_match) begin
                dup <= 1'b1;
              end
              if (cmp.goes_before && !pos_set) begin
                pos     <= chk_idx;
                pos_set <= 1'b1;
              end
            end
            if (iss < count) begin
              iss       <= iss + CW'(1);
              chk_idx   <= iss;
              chk_valid <= 1'b1;
            end else begin
              chk_valid <= 1'b0;
            end
          end
        end
        S_SHIFT_UP: begin
          if (!wv && (p == pos)) begin
            count <= count + CW'(1);
            state <= S_HEAD;
          end
          if (p != pos) begin
            wv <= 1'b1;
            wa <= p;
            p  <= p_dec;
          end else begin
            wv <= 1'b0;
          end
        end
        S_SHIFT_DN: begin
          if (p_inc < count) begin
            wv <= 1'b1;
            wa <= p;
            p  <= p_inc;
          end else begin
            wv <= 1'b0;
            if (!wv) begin
              count <= count - CW'(1);
              state <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          state <= S_REPORT;
        end
        S_REPORT: begin
          taken_valid  <= tv;
          taken_handle <= th;
          head_valid   <= (count != '0);
          head_key     <= (count != '0) ? $signed(rd_data.key) : '0;
          head_x       <= (count != '0) ? $signed(rd_data.x) : '0;
          head_z       <= (count != '0) ? $signed(rd_data.z) : '0;
          entry_total  <= count;
          status       <= st;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SEPQ_ASSERT_NOW(a_done_idle, done, !busy)
  `SEPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `SEPQ_ASSERT_NOW(a_head_count, done, head_valid == (entry_total != '0))
  `SEPQ_ASSERT_NOW(a_full_count, done && (status == ST_FULL), entry_total == CW'(CAPACITY))
  `SEPQ_ASSERT_NOW(a_taken_ok, done && taken_valid, status == ST_OK)

endmodule
